/* hdl/crc16fhb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16fhb_pkg
// Shared types, register indexes and the byte-wide CRC-16/CCITT-FALSE update
// for the frame header builder.
// ----------------------------------------------------------------------------
package crc16fhb_pkg;

	// CRC-16/CCITT-FALSE parameters
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 2'd2;

	// One accepted input beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       carries_byte;
		logic       last_of_frame;
		logic [7:0] frame_type;
	} in_beat_t;

	// Advance the CRC by one byte, MSB first, no reflection
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hdl/crc16_frame_header_builder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_frame_header_builder_top
// Gathers payload bytes of a frame, runs CRC-16/CCITT-FALSE and a saturating
// byte count, and emits the eight-byte frame header on the closing beat.
//
//   channel | signals                                  | role
//   --------+------------------------------------------+---------------------
//   in      | in_valid/in_ready, data_byte,            | one payload beat
//           | carries_byte, last_of_frame, frame_type  |
//   out     | out_valid/out_ready, header_word,        | one header per frame
//           | crc_value, payload_length, length_overflow|
//   cfg     | cfg_we, cfg_index, cfg_data              | write-only registers
//
// One beat per cycle sustained while no closing beat waits on a stalled
// output. A beat is registered in the input stage, then the CRC/count
// update and the header assembly go combinationally into the output
// register, loaded as a closing beat leaves the input stage. The byte-wide
// combinational CRC update sets the path length. A stalled output holds
// only a closing beat in the input stage, and no new beat enters meanwhile.
// Reset sets frame state (CRC 0xFFFF, count 0), config and valid registers.
// ----------------------------------------------------------------------------
module crc16_frame_header_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        carries_byte,
	input  logic        last_of_frame,
	input  logic [7:0]  frame_type,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] header_word,
	output logic [15:0] crc_value,
	output logic [15:0] payload_length,
	output logic        length_overflow,
	// configuration
	input  logic        cfg_we,
	input  logic [crc16fhb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] magic_first_q;
	logic [7:0] magic_second_q;
	logic [7:0] format_version_q;

	logic                   beat_valid_s1;
	crc16fhb_pkg::in_beat_t beat_s1;

	logic [15:0] crc_q;
	logic [15:0] count_q;
	logic        ovf_q;

	logic        out_valid_q;
	logic [63:0] header_q;
	logic [15:0] crc_out_q;
	logic [15:0] len_out_q;
	logic        ovf_out_q;

	logic        out_free;
	logic        s1_advance;
	logic        load_out;
	logic [15:0] crc_next;
	logic [15:0] count_next;
	logic        ovf_next;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q    <= '0;
			magic_second_q   <= '0;
			format_version_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				crc16fhb_pkg::REG_MAGIC_FIRST:    magic_first_q    <= cfg_data;
				crc16fhb_pkg::REG_MAGIC_SECOND:   magic_second_q   <= cfg_data;
				crc16fhb_pkg::REG_FORMAT_VERSION: format_version_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: a closing beat waits for a free output register
	assign out_free   = !out_valid_q || out_ready;
	assign s1_advance = beat_valid_s1 && (!beat_s1.last_of_frame || out_free);
	assign load_out   = s1_advance && beat_s1.last_of_frame;
	assign in_ready   = !beat_valid_s1 || s1_advance;

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			beat_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1.data_byte     <= data_byte;
			beat_s1.carries_byte  <= carries_byte;
			beat_s1.last_of_frame <= last_of_frame;
			beat_s1.frame_type    <= frame_type;
		end
	end

	// Advance CRC and saturating count for a carried byte
	always_comb begin
		crc_next   = crc_q;
		count_next = count_q;
		ovf_next   = ovf_q;
		if (beat_s1.carries_byte) begin
			crc_next = crc16fhb_pkg::crc_byte(crc_q, beat_s1.data_byte);
			if (count_q == crc16fhb_pkg::COUNT_MAX) begin
				ovf_next = 1'b1;
			end else begin
				count_next = count_q + 16'd1;
			end
		end
	end

	// Hold frame state; restart it after a closing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= crc16fhb_pkg::CRC_INIT;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (s1_advance) begin
			if (beat_s1.last_of_frame) begin
				crc_q   <= crc16fhb_pkg::CRC_INIT;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				crc_q   <= crc_next;
				count_q <= count_next;
				ovf_q   <= ovf_next;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Assemble the header, byte 0 in the low bits
	always_ff @(posedge clk) begin
		if (load_out) begin
			header_q  <= {crc_next[15:8], crc_next[7:0],
				count_next[15:8], count_next[7:0],
				beat_s1.frame_type, format_version_q,
				magic_second_q, magic_first_q};
			crc_out_q <= crc_next;
			len_out_q <= count_next;
			ovf_out_q <= ovf_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign header_word     = header_q;
	assign crc_value       = crc_out_q;
	assign payload_length  = len_out_q;
	assign length_overflow = ovf_out_q;

	// Checks
	a_hdr_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (header_word[63:48] == crc_value) &&
			(header_word[47:32] == payload_length))
		else $error("header bytes disagree with crc/length fields");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_overflow |-> payload_length == crc16fhb_pkg::COUNT_MAX)
		else $error("overflow flagged without saturated length");

	a_ovf_state: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == crc16fhb_pkg::COUNT_MAX)
		else $error("overflow state set below saturation");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> beat_valid_s1 && beat_s1.last_of_frame && out_valid_q && !out_ready)
		else $error("input stalled without a blocked closing beat");

endmodule
